[hw/rtl/ttl_keyed_table_with_oldest_eviction_macros.svh]
// assertion macros for the timed record table
`ifndef TTL_KEYED_TABLE_WITH_OLDEST_EVICTION_MACROS_SVH
`define TTL_KEYED_TABLE_WITH_OLDEST_EVICTION_MACROS_SVH

// property must hold at every clock edge out of reset
`define TTLKT_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
	else $error(msg);

// expression must never be true out of reset
`define TTLKT_ASSERT_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
	else $error(msg);

`endif

[hw/rtl/ttlkt_pkg.sv]
package ttlkt_pkg;

	localparam int AGENT_SLOTS       = 16;
	localparam int ENTRIES_PER_AGENT = 8;
	localparam int TOTAL_ENTRIES     = AGENT_SLOTS * ENTRIES_PER_AGENT;
	localparam int ADDR_W            = (TOTAL_ENTRIES > 1) ? $clog2(TOTAL_ENTRIES) : 1;
	localparam int SLOT_IN_W         = 4;

	localparam logic OP_OBSERVE = 1'b0;
	localparam logic OP_EXPIRE  = 1'b1;

	localparam logic [1:0] KIND_EVENT    = 2'd0;
	localparam logic [1:0] KIND_PLAYER   = 2'd1;
	localparam logic [1:0] KIND_CREATURE = 2'd2;

	localparam logic [1:0] ST_ADDED     = 2'd0;
	localparam logic [1:0] ST_REFRESHED = 2'd1;
	localparam logic [1:0] ST_EVICTED   = 2'd2;
	localparam logic [1:0] ST_EXPIRED   = 2'd3;

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_SCAN  = 4'b0010,
		S_DRAIN = 4'b0100,
		S_WRITE = 4'b1000
	} state_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] event_id;
		logic [63:0] guid;
		logic [31:0] target_agent;
		logic [47:0] spawn_map;
		logic [47:0] last_seen;
		logic [48:0] expiry;
		logic [15:0] count;
		logic [31:0] id;
	} rec_t;

	// first record address of a slot, slot number wrapped onto the table
	function automatic logic [ADDR_W-1:0] slot_base(input logic [SLOT_IN_W-1:0] slot);
		logic [ADDR_W-1:0] b;
		b = '0;
		for (int k = 0; k < 2**SLOT_IN_W; k++) begin
			if (slot == SLOT_IN_W'(k))
				b = ADDR_W'((k % AGENT_SLOTS) * ENTRIES_PER_AGENT);
		end
		return b;
	endfunction

endpackage

[hw/rtl/ttl_keyed_table_with_oldest_eviction.sv]
// timed record table, 16 slots of 8 records in one record memory with one
// read and one write port. an item is taken when start is high and busy is
// low; its one result shows on the result ports for exactly one cycle with
// done high, and the receiver cannot hold it off. observe items walk the 8
// records of their slot one per cycle through the memory read port, then
// write once: the reads, a drain of the read register, a write, then the
// result cycle, in which busy is already low and a new item can be taken.
// expire items walk all 128 records the same way. the one memory read port
// and the compare unit behind it pace both walks. valid bits reset to zero
// at once, so no clearing pass is needed after reset.
module ttl_keyed_table_with_oldest_eviction (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        opcode,
	input  logic [3:0]  agent_slot,
	input  logic [1:0]  obs_kind,
	input  logic [31:0] event_id,
	input  logic [63:0] target_guid,
	input  logic [31:0] target_agent,
	input  logic [31:0] spawn_id,
	input  logic [15:0] map_id,
	input  logic [47:0] time_ms,
	input  logic [31:0] ttl_ms,
	output logic        done,
	output logic [1:0]  status,
	output logic [31:0] record_id,
	output logic [15:0] seen_count,
	output logic [31:0] evicted_id,
	output logic [7:0]  expired_count
);

	localparam int AW = ttlkt_pkg::ADDR_W;

	ttlkt_pkg::state_t state_q;

	// latched item
	logic          op_q;
	logic [AW-1:0] base_q;
	logic [1:0]    kind_q;
	logic [31:0]   ev_q;
	logic [63:0]   guid_q;
	logic [31:0]   agent_q;
	logic [31:0]   spawn_q;
	logic [15:0]   map_q;
	logic [47:0]   now_q;
	logic [31:0]   ttl_q;

	// scan counter and read pipeline
	logic [AW-1:0]       cnt_q;
	logic                rd_pend_s1;
	logic [AW-1:0]       rd_addr_s1;
	ttlkt_pkg::rec_t     rd_data_s1;

	// record memory and its valid bits
	ttlkt_pkg::rec_t rec_mem_q [ttlkt_pkg::TOTAL_ENTRIES];
	logic [ttlkt_pkg::TOTAL_ENTRIES-1:0] valid_q;

	// search results of the current observe item
	logic            found_q;
	logic [AW-1:0]   hit_addr_q;
	ttlkt_pkg::rec_t hit_rec_q;
	logic            free_q;
	logic [AW-1:0]   free_addr_q;
	logic            vic_set_q;
	logic [AW-1:0]   vic_addr_q;
	logic [47:0]     vic_ls_q;
	logic [31:0]     vic_id_q;

	logic [7:0]  removed_q;
	logic [31:0] next_id_q;

	// result registers
	logic        done_q;
	logic [1:0]  status_q;
	logic [31:0] record_id_q;
	logic [15:0] seen_count_q;
	logic [31:0] evicted_id_q;
	logic [7:0]  expired_count_q;

	logic            accept;
	logic            rd_en;
	logic [AW-1:0]   rd_addr;
	logic            scan_last;
	logic            cur_valid;
	logic            key_hit;
	logic            better_hit;
	logic            vic_take;
	logic            expired_now;
	logic            wr_en;
	logic [AW-1:0]   wr_addr;
	ttlkt_pkg::rec_t wr_rec;
	logic [48:0]     new_expiry;
	logic [15:0]     hit_count_next;

	assign accept = start && (state_q == ttlkt_pkg::S_IDLE);
	assign busy   = (state_q != ttlkt_pkg::S_IDLE);

	// address sequencer: expire walks the whole table, observe only its slot
	assign rd_en   = (state_q == ttlkt_pkg::S_SCAN);
	assign rd_addr = (op_q == ttlkt_pkg::OP_EXPIRE) ? cnt_q : AW'(base_q + cnt_q);
	assign scan_last = (op_q == ttlkt_pkg::OP_EXPIRE) ?
		(cnt_q == AW'(ttlkt_pkg::TOTAL_ENTRIES - 1)) :
		(cnt_q == AW'(ttlkt_pkg::ENTRIES_PER_AGENT - 1));

	// compare unit working on the record that just came out of the memory
	assign cur_valid = valid_q[rd_addr_s1];

	always_comb begin
		key_hit = 1'b0;
		if (rd_data_s1.kind == kind_q) begin
			case (kind_q)
				ttlkt_pkg::KIND_EVENT: begin
					key_hit = (rd_data_s1.event_id == ev_q);
				end
				ttlkt_pkg::KIND_CREATURE: begin
					// target agent first, then spawn and map, then guid
					if (agent_q != 32'd0)
						key_hit = (rd_data_s1.target_agent == agent_q);
					else if (spawn_q != 32'd0)
						key_hit = (rd_data_s1.spawn_map == {map_q, spawn_q});
					else
						key_hit = (rd_data_s1.guid == guid_q);
				end
				default: begin
					// player sightings and the unused kind go by guid
					key_hit = (rd_data_s1.guid == guid_q);
				end
			endcase
		end
	end

	// lowest id wins among several matches
	assign better_hit = cur_valid && key_hit &&
		(!found_q || (rd_data_s1.id < hit_rec_q.id));

	// oldest last-seen time, ties to the lowest id
	assign vic_take = !vic_set_q || (rd_data_s1.last_seen < vic_ls_q) ||
		((rd_data_s1.last_seen == vic_ls_q) && (rd_data_s1.id < vic_id_q));

	assign expired_now = cur_valid && (rd_data_s1.expiry <= {1'b0, now_q});

	// write-back record
	assign new_expiry     = 49'(now_q) + 49'(ttl_q);
	assign hit_count_next = (hit_rec_q.count == 16'hFFFF) ? 16'hFFFF :
		16'(hit_rec_q.count + 16'd1);
	assign wr_en = (state_q == ttlkt_pkg::S_WRITE) && (op_q == ttlkt_pkg::OP_OBSERVE);

	always_comb begin
		if (found_q) begin
			wr_addr             = hit_addr_q;
			wr_rec              = hit_rec_q;
			wr_rec.last_seen    = now_q;
			wr_rec.expiry       = new_expiry;
			wr_rec.count        = hit_count_next;
			wr_rec.guid         = guid_q;
			wr_rec.target_agent = agent_q;
			wr_rec.spawn_map    = {map_q, spawn_q};
		end else begin
			wr_addr             = free_q ? free_addr_q : vic_addr_q;
			wr_rec.kind         = kind_q;
			wr_rec.event_id     = ev_q;
			wr_rec.guid         = guid_q;
			wr_rec.target_agent = agent_q;
			wr_rec.spawn_map    = {map_q, spawn_q};
			wr_rec.last_seen    = now_q;
			wr_rec.expiry       = new_expiry;
			wr_rec.count        = 16'd1;
			wr_rec.id           = next_id_q;
		end
	end

	// record memory, one read and one write port, registered read
	always_ff @(posedge clk) begin
		if (rd_en)
			rd_data_s1 <= rec_mem_q[rd_addr];
		if (wr_en)
			rec_mem_q[wr_addr] <= wr_rec;
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ttlkt_pkg::S_IDLE;
			cnt_q      <= '0;
			rd_pend_s1 <= 1'b0;
			valid_q    <= '0;
			found_q    <= 1'b0;
			free_q     <= 1'b0;
			vic_set_q  <= 1'b0;
			removed_q  <= '0;
			next_id_q  <= '0;
			done_q     <= 1'b0;
		end else begin
			// result strobe follows the write cycle
			done_q     <= (state_q == ttlkt_pkg::S_WRITE);
			rd_pend_s1 <= rd_en;
			case (state_q)
				ttlkt_pkg::S_IDLE: begin
					if (accept) begin
						state_q   <= ttlkt_pkg::S_SCAN;
						cnt_q     <= '0;
						found_q   <= 1'b0;
						free_q    <= 1'b0;
						vic_set_q <= 1'b0;
						removed_q <= '0;
					end
				end
				ttlkt_pkg::S_SCAN: begin
					cnt_q <= AW'(cnt_q + 1'b1);
					if (scan_last)
						state_q <= ttlkt_pkg::S_DRAIN;
				end
				ttlkt_pkg::S_DRAIN: begin
					state_q <= ttlkt_pkg::S_WRITE;
				end
				ttlkt_pkg::S_WRITE: begin
					state_q <= ttlkt_pkg::S_IDLE;
					if (wr_en) begin
						valid_q[wr_addr] <= 1'b1;
						if (!found_q)
							next_id_q <= 32'(next_id_q + 32'd1);
					end
				end
				default: begin
					state_q <= ttlkt_pkg::S_IDLE;
				end
			endcase

			// per-record bookkeeping as read data comes back
			if (rd_pend_s1) begin
				if (op_q == ttlkt_pkg::OP_EXPIRE) begin
					if (expired_now) begin
						valid_q[rd_addr_s1] <= 1'b0;
						if (removed_q != 8'hFF)
							removed_q <= 8'(removed_q + 8'd1);
					end
				end else begin
					if (!cur_valid)
						free_q <= 1'b1;
					if (better_hit)
						found_q <= 1'b1;
					vic_set_q <= 1'b1;
				end
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q    <= opcode;
			base_q  <= ttlkt_pkg::slot_base(agent_slot);
			kind_q  <= obs_kind;
			ev_q    <= event_id;
			guid_q  <= target_guid;
			agent_q <= target_agent;
			spawn_q <= spawn_id;
			map_q   <= map_id;
			now_q   <= time_ms;
			ttl_q   <= ttl_ms;
		end

		if (rd_en)
			rd_addr_s1 <= rd_addr;

		if (rd_pend_s1 && (op_q == ttlkt_pkg::OP_OBSERVE)) begin
			// first free place in the slot
			if (!cur_valid && !free_q)
				free_addr_q <= rd_addr_s1;
			if (better_hit) begin
				hit_addr_q <= rd_addr_s1;
				hit_rec_q  <= rd_data_s1;
			end
			if (vic_take) begin
				vic_addr_q <= rd_addr_s1;
				vic_ls_q   <= rd_data_s1.last_seen;
				vic_id_q   <= rd_data_s1.id;
			end
		end

		if (state_q == ttlkt_pkg::S_WRITE) begin
			if (op_q == ttlkt_pkg::OP_EXPIRE) begin
				status_q        <= ttlkt_pkg::ST_EXPIRED;
				record_id_q     <= '0;
				seen_count_q    <= '0;
				evicted_id_q    <= '0;
				expired_count_q <= removed_q;
			end else if (found_q) begin
				status_q        <= ttlkt_pkg::ST_REFRESHED;
				record_id_q     <= hit_rec_q.id;
				seen_count_q    <= hit_count_next;
				evicted_id_q    <= '0;
				expired_count_q <= '0;
			end else begin
				status_q        <= free_q ? ttlkt_pkg::ST_ADDED : ttlkt_pkg::ST_EVICTED;
				record_id_q     <= next_id_q;
				seen_count_q    <= 16'd1;
				evicted_id_q    <= free_q ? 32'd0 : vic_id_q;
				expired_count_q <= '0;
			end
		end
	end

	assign done          = done_q;
	assign status        = status_q;
	assign record_id     = record_id_q;
	assign seen_count    = seen_count_q;
	assign evicted_id    = evicted_id_q;
	assign expired_count = expired_count_q;

endmodule

[hw/rtl/ttlkt_chk.sv]
`include "ttl_keyed_table_with_oldest_eviction_macros.svh"

module ttlkt_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input logic [1:0]  status,
	input logic [15:0] seen_count,
	input logic [31:0] evicted_id,
	input logic [7:0]  expired_count
);

	// a result only shows once the block is free again
	`TTLKT_ASSERT_NEVER(a_done_while_busy, done && busy, "result shown while busy")

	// an accepted item keeps the block busy in the next cycle
	`TTLKT_ASSERT(a_accept_busy, start && !busy |=> busy, "accepted item did not start work")

	`TTLKT_ASSERT(a_evicted_zero, done && (status != ttlkt_pkg::ST_EVICTED) |-> evicted_id == 32'd0, "evicted id set without eviction")

	`TTLKT_ASSERT(a_expired_zero, done && (status != ttlkt_pkg::ST_EXPIRED) |-> expired_count == 8'd0, "expired count set on observe item")

	`TTLKT_ASSERT(a_new_count, done && ((status == ttlkt_pkg::ST_ADDED) || (status == ttlkt_pkg::ST_EVICTED)) |-> seen_count == 16'd1, "new record count not one")

endmodule

bind ttl_keyed_table_with_oldest_eviction ttlkt_chk u_ttlkt_chk (.*);
